FILE: hw/rtl/rolling_hash_substring_matcher_defines.svh
// ----------------------------------------------------------------------------
// rolling_hash_substring_matcher_defines
// Assertion macros used by the matcher controller.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH

// same-cycle implication
`define RHSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RHSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rhsm_pkg.sv
// ----------------------------------------------------------------------------
// rhsm_pkg
// Types, constants and helpers of the rolling hash substring matcher.
// ----------------------------------------------------------------------------
package rhsm_pkg;

  localparam int MAX_PAT  = 16;
  localparam int IDX_W    = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int LEN_W    = $clog2(MAX_PAT + 1);
  localparam int HASH_W   = 26;
  localparam int POS_BITS = 32;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int KIND_W   = 2;

  // multiplicative inverse of 3 modulo 2^HASH_W
  localparam logic [HASH_W-1:0] INV3 = HASH_W'(64'hAAAA_AAAA_AAAA_AAAB);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_TEXT = 2'd1,
    CMD_END  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HASH  = 2'd0,
    KIND_POS   = 2'd1,
    KIND_SHORT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_LOAD  = 2'd0,
    PH_FILL  = 2'd1,
    PH_MATCH = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT_HASH,
    ST_CMP,
    ST_EMIT_SHORT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILL,
    OP_ROLL,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic   latch;
    dp_op_t op;
    logic   idx_clr;
    logic   idx_inc;
    kind_t  emit;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    phase_t phase;
    logic   plen_zero;
    logic   plen_full;
    logic   fill_done;
    logic   fill_hit;
    logic   roll_hit;
    logic   cmp_last;
  } dp_sts_t;

  // byte mod 3 via reciprocal multiply
  function automatic logic [1:0] mod3(input logic [7:0] b);
    logic [15:0] prod;
    logic [6:0]  q;
    logic [9:0]  r;
    prod = 16'(b) * 16'd171;
    q    = prod[15:9];
    r    = 10'(b) - 10'(q) * 10'd3;
    return r[1:0];
  endfunction

  // weight times a digit in 0..2
  function automatic logic [HASH_W-1:0] scale(input logic [1:0] m,
                                              input logic [HASH_W-1:0] w);
    logic [HASH_W-1:0] res;
    unique case (m)
      2'd1:    res = w;
      2'd2:    res = {w[HASH_W-2:0], 1'b0};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/rhsm_if.sv
// ----------------------------------------------------------------------------
// rhsm_if
// Request channels of the matcher: input commands and result items.
// ----------------------------------------------------------------------------
interface rhsm_in_if;
  logic                       valid;
  logic                       ready;
  logic [rhsm_pkg::CMD_W-1:0] command;
  logic [7:0]                 data;

  modport source (output valid, output command, output data, input ready);
  modport sink (input valid, input command, input data, output ready);
endinterface

interface rhsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [rhsm_pkg::KIND_W-1:0] kind;
  logic [rhsm_pkg::VAL_W-1:0]  value;
  logic                        last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

FILE: hw/rtl/rhsm_datapath.sv
// ----------------------------------------------------------------------------
// rhsm_datapath
// Pattern and window stores, hash registers, position counter, compare index.
// ----------------------------------------------------------------------------
module rhsm_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rhsm_pkg::CMD_W-1:0]  in_command,
  input  logic [7:0]                  in_data,
  input  rhsm_pkg::dp_cmd_t           cmd,
  output rhsm_pkg::dp_sts_t           sts,
  output logic [rhsm_pkg::KIND_W-1:0] out_kind,
  output logic [rhsm_pkg::VAL_W-1:0]  out_value,
  output logic                        out_last
);

  localparam int HW = rhsm_pkg::HASH_W;
  localparam int LW = rhsm_pkg::LEN_W;
  localparam int IW = rhsm_pkg::IDX_W;
  localparam int PB = rhsm_pkg::POS_BITS;
  localparam int MP = rhsm_pkg::MAX_PAT;

  rhsm_pkg::cmd_t   cmd_r;
  logic [7:0]       data_r;
  logic [7:0]       pat_r [MP];
  logic [7:0]       win_r [MP];

  logic [LW-1:0]    plen_r,   plen_nxt;
  logic [LW-1:0]    wfill_r,  wfill_nxt;
  logic [HW-1:0]    phash_r,  phash_nxt;
  logic [HW-1:0]    whash_r,  whash_nxt;
  logic [HW-1:0]    top_r,    top_nxt;
  logic [HW-1:0]    fw_r,     fw_nxt;
  logic [PB-1:0]    wstart_r, wstart_nxt;
  rhsm_pkg::phase_t phase_r,  phase_nxt;
  logic             hit_r,    hit_nxt;
  logic [IW-1:0]    idx_r,    idx_nxt;
  logic [HW-1:0]    q_r,      q_nxt;

  logic [1:0]       m;
  logic [HW-1:0]    load_top;
  logic [HW-1:0]    fill_hash;
  logic [HW-1:0]    roll_hash;
  logic             fill_done;
  logic [PB:0]      pos_sum;
  logic [PB-1:0]    pos_sat;
  logic [63:0]      pos_ext;
  logic [rhsm_pkg::VAL_W-1:0] pos_val;

  assign m         = rhsm_pkg::mod3(data_r);
  assign load_top  = (plen_r == '0) ? top_r : HW'(top_r + {top_r[HW-2:0], 1'b0});
  assign fill_hash = HW'(whash_r + rhsm_pkg::scale(m, fw_r));
  assign roll_hash = HW'(q_r + rhsm_pkg::scale(m, top_r));
  assign fill_done = (LW'(wfill_r + LW'(1)) >= plen_r);

  // exact divide by 3 of (hash - oldest digit)
  assign q_nxt = HW'((whash_r - HW'(rhsm_pkg::mod3(win_r[0]))) * rhsm_pkg::INV3);

  assign pos_sum = {1'b0, wstart_r} + (PB+1)'(idx_r) + (PB+1)'(1);
  assign pos_sat = pos_sum[PB] ? '1 : pos_sum[PB-1:0];
  assign pos_ext = 64'(pos_sat);
  assign pos_val = (pos_ext > 64'hFFFF_FFFF) ? '1 : pos_ext[rhsm_pkg::VAL_W-1:0];

  always_comb begin
    plen_nxt   = plen_r;
    wfill_nxt  = wfill_r;
    phash_nxt  = phash_r;
    whash_nxt  = whash_r;
    top_nxt    = top_r;
    fw_nxt     = fw_r;
    wstart_nxt = wstart_r;
    phase_nxt  = phase_r;
    hit_nxt    = hit_r;
    idx_nxt    = idx_r;
    unique case (cmd.op)
      rhsm_pkg::OP_LOAD: begin
        top_nxt   = load_top;
        phash_nxt = HW'(phash_r + rhsm_pkg::scale(m, load_top));
        plen_nxt  = LW'(plen_r + LW'(1));
      end
      rhsm_pkg::OP_FILL: begin
        whash_nxt = fill_hash;
        fw_nxt    = HW'(fw_r + {fw_r[HW-2:0], 1'b0});
        wfill_nxt = LW'(wfill_r + LW'(1));
        hit_nxt   = (fill_hash == phash_r);
        if (fill_done) begin
          phase_nxt  = rhsm_pkg::PH_MATCH;
          wstart_nxt = '0;
        end else begin
          phase_nxt = rhsm_pkg::PH_FILL;
        end
      end
      rhsm_pkg::OP_ROLL: begin
        whash_nxt = roll_hash;
        if (wstart_r != '1) begin
          wstart_nxt = PB'(wstart_r + PB'(1));
        end
      end
      rhsm_pkg::OP_CLEAR: begin
        plen_nxt   = '0;
        wfill_nxt  = '0;
        phash_nxt  = '0;
        whash_nxt  = '0;
        top_nxt    = HW'(1);
        fw_nxt     = HW'(1);
        wstart_nxt = '0;
        phase_nxt  = rhsm_pkg::PH_LOAD;
      end
      default: begin
      end
    endcase
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = IW'(idx_r + IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= '0;
      wfill_r  <= '0;
      phash_r  <= '0;
      whash_r  <= '0;
      top_r    <= HW'(1);
      fw_r     <= HW'(1);
      wstart_r <= '0;
      phase_r  <= rhsm_pkg::PH_LOAD;
      hit_r    <= 1'b0;
      idx_r    <= '0;
    end else begin
      plen_r   <= plen_nxt;
      wfill_r  <= wfill_nxt;
      phash_r  <= phash_nxt;
      whash_r  <= whash_nxt;
      top_r    <= top_nxt;
      fw_r     <= fw_nxt;
      wstart_r <= wstart_nxt;
      phase_r  <= phase_nxt;
      hit_r    <= hit_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (cmd.latch) begin
      cmd_r  <= rhsm_pkg::cmd_t'(in_command);
      data_r <= in_data;
    end
    if (cmd.op == rhsm_pkg::OP_LOAD) begin
      pat_r[plen_r[IW-1:0]] <= data_r;
    end
    for (int i = 0; i < MP; i++) begin
      if (cmd.op == rhsm_pkg::OP_FILL && wfill_r[IW-1:0] == IW'(i)) begin
        win_r[i] <= data_r;
      end else if (cmd.op == rhsm_pkg::OP_ROLL) begin
        if (plen_r == LW'(i + 1)) begin
          win_r[i] <= data_r;
        end else if (plen_r > LW'(i + 1)) begin
          win_r[i] <= win_r[(i + 1) % MP];
        end
      end
    end
  end

  always_comb begin
    sts.cmd       = cmd_r;
    sts.phase     = phase_r;
    sts.plen_zero = (plen_r == '0);
    sts.plen_full = (plen_r >= LW'(MP));
    sts.fill_done = fill_done;
    sts.fill_hit  = hit_r;
    sts.roll_hit  = (roll_hash == phash_r);
    sts.cmp_last  = (pat_r[idx_r] != win_r[idx_r]) ||
                    (LW'(LW'(idx_r) + LW'(1)) == plen_r);
  end

  always_comb begin
    out_kind = cmd.emit;
    unique case (cmd.emit)
      rhsm_pkg::KIND_HASH: begin
        out_value = rhsm_pkg::VAL_W'(phash_r);
        out_last  = !hit_r;
      end
      rhsm_pkg::KIND_POS: begin
        out_value = pos_val;
        out_last  = sts.cmp_last;
      end
      default: begin
        out_value = '0;
        out_last  = 1'b1;
      end
    endcase
  end

endmodule

FILE: hw/rtl/rhsm_controller.sv
// ----------------------------------------------------------------------------
// rhsm_controller
// Sequencer: takes one request, runs its datapath step, emits its results.
// ----------------------------------------------------------------------------
`include "rolling_hash_substring_matcher_defines.svh"

module rhsm_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rhsm_pkg::dp_sts_t sts,
  output rhsm_pkg::dp_cmd_t cmd
);

  rhsm_pkg::state_t state_r, state_nxt;
  logic             out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhsm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.latch   = 1'b0;
    cmd.op      = rhsm_pkg::OP_NONE;
    cmd.idx_clr = 1'b0;
    cmd.idx_inc = 1'b0;
    cmd.emit    = rhsm_pkg::KIND_HASH;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      rhsm_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = rhsm_pkg::ST_EXEC;
        end
      end
      rhsm_pkg::ST_EXEC: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = rhsm_pkg::ST_IDLE;
        unique case (sts.cmd)
          rhsm_pkg::CMD_LOAD: begin
            if (sts.phase == rhsm_pkg::PH_LOAD && !sts.plen_full) begin
              cmd.op = rhsm_pkg::OP_LOAD;
            end
          end
          rhsm_pkg::CMD_TEXT: begin
            priority if (sts.phase == rhsm_pkg::PH_LOAD && sts.plen_zero) begin
              cmd.op = rhsm_pkg::OP_NONE;
            end else if (sts.phase != rhsm_pkg::PH_MATCH) begin
              cmd.op = rhsm_pkg::OP_FILL;
              if (sts.fill_done) begin
                state_nxt = rhsm_pkg::ST_EMIT_HASH;
              end
            end else begin
              cmd.op = rhsm_pkg::OP_ROLL;
              if (sts.roll_hit) begin
                state_nxt = rhsm_pkg::ST_CMP;
              end
            end
          end
          rhsm_pkg::CMD_END: begin
            cmd.op = rhsm_pkg::OP_CLEAR;
            if (!sts.plen_zero && sts.phase != rhsm_pkg::PH_MATCH) begin
              state_nxt = rhsm_pkg::ST_EMIT_SHORT;
            end
          end
          default: begin
          end
        endcase
      end
      rhsm_pkg::ST_EMIT_HASH: begin
        out_valid = 1'b1;
        cmd.emit  = rhsm_pkg::KIND_HASH;
        if (out_ready) begin
          // hash hit after fill: last is low, go compare
          state_nxt = sts.fill_hit ? rhsm_pkg::ST_CMP : rhsm_pkg::ST_IDLE;
        end
      end
      rhsm_pkg::ST_CMP: begin
        out_valid = 1'b1;
        cmd.emit  = rhsm_pkg::KIND_POS;
        if (out_ready) begin
          if (sts.cmp_last) begin
            state_nxt = rhsm_pkg::ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      rhsm_pkg::ST_EMIT_SHORT: begin
        out_valid = 1'b1;
        cmd.emit  = rhsm_pkg::KIND_SHORT;
        if (out_ready) begin
          state_nxt = rhsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rhsm_pkg::ST_IDLE;
      end
    endcase
  end

  `RHSM_ASSERT_NOW(a_hash_in_match, state_r == rhsm_pkg::ST_EMIT_HASH, sts.phase == rhsm_pkg::PH_MATCH, "hash result outside match phase")
  `RHSM_ASSERT_NOW(a_cmp_in_match, state_r == rhsm_pkg::ST_CMP, sts.phase == rhsm_pkg::PH_MATCH && !sts.plen_zero, "compare without pattern")
  `RHSM_ASSERT_NOW(a_short_cleared, state_r == rhsm_pkg::ST_EMIT_SHORT, sts.plen_zero && sts.phase == rhsm_pkg::PH_LOAD, "short result before clear")
  `RHSM_ASSERT_NEXT(a_cmp_end, state_r == rhsm_pkg::ST_CMP && out_fire && sts.cmp_last, state_r == rhsm_pkg::ST_IDLE, "compare run did not end")

endmodule

FILE: hw/rtl/rolling_hash_substring_matcher.sv
// ----------------------------------------------------------------------------
// rolling_hash_substring_matcher
// Flow: a request is taken while idle and executed in the next cycle; its first
// result is offered the cycle after that. One request at a time: no new request
// is taken until all result items of the last one (up to 17) are accepted.
// Reset: synchronous active-low rst_n clears pattern length, hashes, fill,
// position and phase; no clearing pass.
// ----------------------------------------------------------------------------
module rolling_hash_substring_matcher (
  input  logic       clk,
  input  logic       rst_n,
  rhsm_in_if.sink    in_ch,
  rhsm_out_if.source out_ch
);

  rhsm_pkg::dp_cmd_t dp_cmd;
  rhsm_pkg::dp_sts_t dp_sts;
  logic              ctl_in_ready;
  logic              ctl_out_valid;
  logic [rhsm_pkg::KIND_W-1:0] dp_kind;
  logic [rhsm_pkg::VAL_W-1:0]  dp_value;
  logic                        dp_last;

  rhsm_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (ctl_in_ready),
    .out_valid (ctl_out_valid),
    .out_ready (out_ch.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  rhsm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_command (in_ch.command),
    .in_data    (in_ch.data),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .out_kind   (dp_kind),
    .out_value  (dp_value),
    .out_last   (dp_last)
  );

  assign in_ch.ready  = ctl_in_ready;
  assign out_ch.valid = ctl_out_valid;
  assign out_ch.kind  = dp_kind;
  assign out_ch.value = dp_value;
  assign out_ch.last  = dp_last;

endmodule
